### design/dfir_pkg.sv
// shared types and constants of the decimating fir filter
// no dependencies; used by the front, queue, back and top level files
package dfir_pkg;

    localparam int SAMPLE_W     = 16;
    localparam int COEF_W       = 16;
    localparam int IDX_W        = 6;
    localparam int FACTOR_W     = 8;
    localparam logic [FACTOR_W-1:0] FACTOR_RESET = 8'd4;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_COEF   = 1'b1;

    // one command from the front to the back
    typedef struct packed {
        logic                kind;
        logic                emit;
        logic [SAMPLE_W-1:0] data;
        logic [IDX_W-1:0]    index;
    } t_cmd;

endpackage

### design/decimating_fir_filter.sv
// Decimating FIR filter with TAPS coefficients loaded by coefficient-write beats.
// A sample beat or coefficient beat is taken into a two-entry queue and retired
// by the back end while it is idle; a sample that completes a decimation period
// then runs a multiply-accumulate over all TAPS taps, one tap per cycle through
// a single multiplier with registered store reads, so that beat occupies the
// back end until its result sits in the output register. Inputs keep flowing
// into the queue meanwhile until its two entries are full.
// Depends on dfir_pkg, dfir_front, dfir_queue and dfir_back.
module decimating_fir_filter #(
    parameter int TAPS = 50
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic                                 i_mode,
    input  logic signed [dfir_pkg::SAMPLE_W-1:0] i_sample,
    input  logic [dfir_pkg::IDX_W-1:0]           i_coef_index,
    input  logic signed [dfir_pkg::COEF_W-1:0]   i_coef_value,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [dfir_pkg::FACTOR_W-1:0]        i_cfg_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [dfir_pkg::SAMPLE_W-1:0] o_filtered_sample
);

    logic           w_push;
    logic           w_full;
    logic           w_pop;
    logic           w_q_valid;
    dfir_pkg::t_cmd w_cmd_in;
    dfir_pkg::t_cmd w_cmd_out;

    dfir_front #(.TAPS(TAPS)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_mode       (i_mode),
        .i_sample     (i_sample),
        .i_coef_index (i_coef_index),
        .i_coef_value (i_coef_value),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_q_full     (w_full),
        .o_push       (w_push),
        .o_cmd        (w_cmd_in)
    );

    dfir_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_cmd   (w_cmd_out)
    );

    dfir_back #(.TAPS(TAPS)) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_valid         (w_q_valid),
        .i_cmd             (w_cmd_out),
        .o_pop             (w_pop),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_filtered_sample (o_filtered_sample)
    );

endmodule

### design/dfir_front.sv
// front end: input and configuration handshakes, decimation count, command build
// depends on dfir_pkg
module dfir_front #(
    parameter int TAPS = 50
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_mode,
    input  logic signed [dfir_pkg::SAMPLE_W-1:0] i_sample,
    input  logic [dfir_pkg::IDX_W-1:0]          i_coef_index,
    input  logic signed [dfir_pkg::COEF_W-1:0]  i_coef_value,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [dfir_pkg::FACTOR_W-1:0]       i_cfg_data,
    input  logic                                i_q_full,
    output logic                                o_push,
    output dfir_pkg::t_cmd                      o_cmd
);

    logic [dfir_pkg::FACTOR_W-1:0] r_factor;
    logic [dfir_pkg::FACTOR_W-1:0] r_count;
    logic [dfir_pkg::FACTOR_W-1:0] n_count;
    logic                          w_emit;
    logic                          w_idx_ok;
    logic                          w_accept;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !i_q_full;
    assign w_accept    = i_in_valid && o_in_ready;

    assign n_count  = r_count + 1'b1;
    assign w_emit   = (n_count >= r_factor);
    assign w_idx_ok = (int'(i_coef_index) < TAPS);

    // coefficient writes beyond the last tap are dropped here
    assign o_push = w_accept && ((i_mode == dfir_pkg::KIND_SAMPLE) || w_idx_ok);

    always_comb begin
        o_cmd.kind  = i_mode;
        o_cmd.emit  = (i_mode == dfir_pkg::KIND_SAMPLE) && w_emit;
        o_cmd.data  = (i_mode == dfir_pkg::KIND_SAMPLE) ? i_sample : i_coef_value;
        o_cmd.index = i_coef_index;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_factor <= dfir_pkg::FACTOR_RESET;
            r_count  <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_factor <= i_cfg_data;
            end
            if (w_accept && (i_mode == dfir_pkg::KIND_SAMPLE)) begin
                r_count <= w_emit ? '0 : n_count;
            end
        end
    end

endmodule

### design/dfir_queue.sv
// two-entry command queue between front and back
// depends on dfir_pkg
module dfir_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  dfir_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output dfir_pkg::t_cmd o_cmd
);

    dfir_pkg::t_cmd r_mem [2];
    logic           r_wr;
    logic           r_rd;
    logic [1:0]     r_cnt;
    logic           w_push;
    logic           w_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= !r_wr;
            end
            if (w_pop) begin
                r_rd <= !r_rd;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

### design/dfir_back.sv
// back end: sample and coefficient stores, multiply-accumulate sequencer,
// output scaling and output register; depends on dfir_pkg
module dfir_back #(
    parameter int TAPS = 50
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_q_valid,
    input  dfir_pkg::t_cmd                       i_cmd,
    output logic                                 o_pop,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [dfir_pkg::SAMPLE_W-1:0] o_filtered_sample
);

    localparam int AW    = $clog2(TAPS);
    localparam int PW    = dfir_pkg::SAMPLE_W + dfir_pkg::COEF_W;
    localparam int ACC_W = PW + $clog2(TAPS);
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((2 ** (dfir_pkg::SAMPLE_W - 1)) - 1);
    localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - 1;
    localparam logic [AW-1:0] LAST = AW'(TAPS - 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [dfir_pkg::SAMPLE_W-1:0] mem_s [TAPS];
    logic [dfir_pkg::COEF_W-1:0]   mem_c [TAPS];
    logic [TAPS-1:0]               r_sv;
    logic [TAPS-1:0]               r_cv;

    logic [1:0]     r_state;
    logic [1:0]     n_state;
    logic [AW-1:0]  r_wp;
    logic [AW-1:0]  n_wp;
    logic [AW-1:0]  r_pos;
    logic [AW-1:0]  r_k;
    logic           r_issuing;
    logic           r_v1;
    logic           r_v2;

    logic signed [dfir_pkg::SAMPLE_W-1:0] r_s_rd;
    logic signed [dfir_pkg::COEF_W-1:0]   r_c_rd;
    logic                                 r_s_ok;
    logic                                 r_c_ok;
    logic signed [PW-1:0]                 r_prod;
    logic signed [ACC_W-1:0]              r_acc;
    logic signed [ACC_W-1:0]              w_shift;
    logic signed [dfir_pkg::SAMPLE_W-1:0] w_sat;
    logic [AW+dfir_pkg::IDX_W-1:0]        w_cidx_ext;
    logic [AW-1:0]                        w_caddr;
    logic                                 w_load;

    assign o_pop      = (r_state == S_IDLE) && i_q_valid;
    assign w_cidx_ext = {{AW{1'b0}}, i_cmd.index};
    assign w_caddr    = w_cidx_ext[AW-1:0];
    assign n_wp       = (r_wp == LAST) ? '0 : r_wp + 1'b1;
    assign w_load     = (r_state == S_FIN) && (!o_out_valid || i_out_ready);

    // arithmetic shift floors, then clamp to the output range
    assign w_shift = r_acc >>> (dfir_pkg::COEF_W - 1);
    always_comb begin
        if (w_shift > SAT_HI) begin
            w_sat = SAT_HI[dfir_pkg::SAMPLE_W-1:0];
        end else if (w_shift < SAT_LO) begin
            w_sat = SAT_LO[dfir_pkg::SAMPLE_W-1:0];
        end else begin
            w_sat = w_shift[dfir_pkg::SAMPLE_W-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (o_pop && (i_cmd.kind == dfir_pkg::KIND_SAMPLE) && i_cmd.emit) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (!r_issuing && !r_v1 && !r_v2) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // store writes and registered reads
    always_ff @(posedge i_clk) begin
        if (o_pop && (i_cmd.kind == dfir_pkg::KIND_SAMPLE)) begin
            mem_s[r_wp] <= i_cmd.data;
        end
        if (o_pop && (i_cmd.kind == dfir_pkg::KIND_COEF)) begin
            mem_c[w_caddr] <= i_cmd.data;
        end
        r_s_rd <= mem_s[r_pos];
        r_c_rd <= mem_c[r_k];
    end

    // datapath, no reset needed
    always_ff @(posedge i_clk) begin
        r_s_ok <= r_sv[r_pos];
        r_c_ok <= r_cv[r_k];
        // entries never written read as zero
        if (r_s_ok && r_c_ok) begin
            r_prod <= r_s_rd * r_c_rd;
        end else begin
            r_prod <= '0;
        end
        if (o_pop) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_acc + {{(ACC_W-PW){r_prod[PW-1]}}, r_prod};
        end
        if (w_load) begin
            o_filtered_sample <= w_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sv        <= '0;
            r_cv        <= '0;
            r_wp        <= '0;
            r_pos       <= '0;
            r_k         <= '0;
            r_issuing   <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v1    <= r_issuing;
            r_v2    <= r_v1;
            if (o_pop && (i_cmd.kind == dfir_pkg::KIND_SAMPLE)) begin
                r_sv[r_wp] <= 1'b1;
                r_wp       <= n_wp;
                // oldest sample sits at the next write slot
                r_pos      <= n_wp;
                r_k        <= '0;
                r_issuing  <= i_cmd.emit;
            end else if (r_issuing) begin
                r_pos <= (r_pos == LAST) ? '0 : r_pos + 1'b1;
                if (r_k == LAST) begin
                    r_issuing <= 1'b0;
                end else begin
                    r_k <= r_k + 1'b1;
                end
            end
            if (o_pop && (i_cmd.kind == dfir_pkg::KIND_COEF)) begin
                r_cv[w_caddr] <= 1'b1;
            end
            if (w_load) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

`ifndef ASSERT_OFF
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!r_v1 && !r_v2))
        else $error("mac pipeline busy while idle");

    a_issue_only_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_issuing |-> (r_state == S_RUN))
        else $error("tap reads issued outside run state");

    a_fin_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |-> (!r_issuing && !r_v1 && !r_v2))
        else $error("result taken before accumulation finished");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (o_out_valid && (r_state == S_IDLE)))
        else $error("finished result not presented");
`endif

endmodule
